>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL that checks itself.
// Every macro expects signals named clk and rst in the scope of its use.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, muted during reset.
`define SWFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, muted during reset.
`define SWFR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/swfr_pkg.sv
// ---------------------------------------------------------------------------
// swfr_pkg
// Types and constants of the stop-and-wait frame receiver.
// ---------------------------------------------------------------------------
package swfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int KIND_W   = 2;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_FLAG  = 8'h5E;
  localparam logic [BYTE_W-1:0] ESC_ESC   = 8'h5D;
  localparam logic [BYTE_W-1:0] RR_BASE   = 8'h05;
  localparam logic [BYTE_W-1:0] REJ_BASE  = 8'h01;

  localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h03;
  localparam logic [BYTE_W-1:0] SEQ0_RESET = 8'h00;
  localparam logic [BYTE_W-1:0] SEQ1_RESET = 8'h40;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Register indexes (paddr[3:2]).
  typedef enum logic [1:0] {
    REG_ADDRESS = 2'd0,
    REG_SEQ0    = 2'd1,
    REG_SEQ1    = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    RES_PAYLOAD = 2'd0,
    RES_ACCEPT  = 2'd1,
    RES_REJECT  = 2'd2,
    RES_SEQ     = 2'd3
  } res_kind_t;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_FLAG = 6'b000010,
    PH_ADDR = 6'b000100,
    PH_CTRL = 6'b001000,
    PH_DATA = 6'b010000,
    PH_DROP = 6'b100000
  } phase_t;

  typedef struct packed {
    res_kind_t          kind;
    logic [BYTE_W-1:0]  data;
    logic [LEN_W-1:0]   len;
  } res_word_t;

  function automatic logic [BYTE_W-1:0] rr_code(input logic seq);
    return {seq, RR_BASE[BYTE_W-2:0]};
  endfunction

  function automatic logic [BYTE_W-1:0] rej_code(input logic seq);
    return {seq, REJ_BASE[BYTE_W-2:0]};
  endfunction

endpackage

>>> rtl/swfr_rx_if.sv
// ---------------------------------------------------------------------------
// swfr_rx_if
// Valid/ready channel carrying one raw line byte per word.
// ---------------------------------------------------------------------------
interface swfr_rx_if;
  logic                        valid;
  logic                        ready;
  logic [swfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/swfr_res_if.sv
// ---------------------------------------------------------------------------
// swfr_res_if
// Valid/ready channel carrying one receiver result per word.
// ---------------------------------------------------------------------------
interface swfr_res_if;
  logic                        valid;
  logic                        ready;
  logic [swfr_pkg::KIND_W-1:0] result_type;
  logic [swfr_pkg::BYTE_W-1:0] data_byte;
  logic [swfr_pkg::LEN_W-1:0]  payload_length;

  modport source (output valid, output result_type, output data_byte,
                  output payload_length, input ready);
  modport sink   (input valid, input result_type, input data_byte,
                  input payload_length, output ready);
endinterface

>>> rtl/stop_wait_frame_receiver.sv
// ---------------------------------------------------------------------------
// stop_wait_frame_receiver
// Receive side of a stop-and-wait link: header hunt, byte destuffing,
// BCC2 check and RR/REJ reporting, one line byte per clock while rx.ready is high.
// ---------------------------------------------------------------------------
//
//  channel  | dir | word contents                               | handshake
//  ---------+-----+---------------------------------------------+----------
//  rx       | in  | rx_byte                                     | valid/ready
//  result   | out | result_type, data_byte, payload_length      | valid/ready
//  apb      | in  | address_byte, control_seq0, control_seq1    | psel/penable
//
//  Cycles: one byte per clock unless rx.ready is low; the parser state and
//  any result are both registered at the edge that takes the byte, the result
//  into the output register, or into the skid while the output is held.
//  Reset (rst, synchronous): hunt for an opening flag, expect sequence 0,
//  registers back to address 03, seq0 00, seq1 40.
//  Stalls: a two-word output buffer (output register plus skid) lets rx
//  keep flowing while result is held; rx.ready drops only when both are full.
//
`include "assert_macros.svh"

module stop_wait_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  swfr_rx_if.sink                       rx,
  swfr_res_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swfr_pkg::CFG_AW-1:0]   paddr,
  input  logic [swfr_pkg::CFG_DW-1:0]   pwdata,
  output logic [swfr_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  // ---- configuration registers ------------------------------------------
  logic [swfr_pkg::BYTE_W-1:0] address_byte;
  logic [swfr_pkg::BYTE_W-1:0] control_seq0;
  logic [swfr_pkg::BYTE_W-1:0] control_seq1;
  swfr_pkg::reg_idx_t          reg_idx;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = swfr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= swfr_pkg::ADDR_RESET;
      control_seq0 <= swfr_pkg::SEQ0_RESET;
      control_seq1 <= swfr_pkg::SEQ1_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        swfr_pkg::REG_ADDRESS: address_byte <= pwdata[swfr_pkg::BYTE_W-1:0];
        swfr_pkg::REG_SEQ0:    control_seq0 <= pwdata[swfr_pkg::BYTE_W-1:0];
        swfr_pkg::REG_SEQ1:    control_seq1 <= pwdata[swfr_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swfr_pkg::REG_ADDRESS: prdata = {{(swfr_pkg::CFG_DW-swfr_pkg::BYTE_W){1'b0}}, address_byte};
      swfr_pkg::REG_SEQ0:    prdata = {{(swfr_pkg::CFG_DW-swfr_pkg::BYTE_W){1'b0}}, control_seq0};
      swfr_pkg::REG_SEQ1:    prdata = {{(swfr_pkg::CFG_DW-swfr_pkg::BYTE_W){1'b0}}, control_seq1};
      default:               prdata = '0;
    endcase
  end

  // ---- parser state -----------------------------------------------------
  swfr_pkg::phase_t             phase, phase_next;
  logic [swfr_pkg::BYTE_W-1:0]  seen_control, seen_control_next;
  logic                         expected_seq, expected_seq_next;
  logic                         escape_pending, escape_pending_next;
  logic [swfr_pkg::BYTE_W-1:0]  parity_acc, parity_acc_next;
  logic [swfr_pkg::BYTE_W-1:0]  held_byte, held_byte_next;
  logic                         held_valid, held_valid_next;
  logic [swfr_pkg::LEN_W-1:0]   byte_count, byte_count_next;

  logic                         rx_acc;
  logic                         have_res;
  swfr_pkg::res_word_t          res_new;
  logic                         push_en;
  logic [swfr_pkg::BYTE_W-1:0]  push_val;
  logic [swfr_pkg::BYTE_W-1:0]  b;
  logic [swfr_pkg::BYTE_W-1:0]  want;

  // ---- output buffer ----------------------------------------------------
  swfr_pkg::res_word_t out_word, skid_word;
  logic                out_valid, skid_valid;
  logic                pop, push;

  assign rx.ready = !skid_valid;
  assign rx_acc   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign want     = expected_seq ? control_seq1 : control_seq0;

  always_comb begin
    phase_next          = phase;
    seen_control_next   = seen_control;
    expected_seq_next   = expected_seq;
    escape_pending_next = escape_pending;
    parity_acc_next     = parity_acc;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    byte_count_next     = byte_count;
    have_res            = 1'b0;
    res_new             = '{kind: swfr_pkg::RES_PAYLOAD, data: '0, len: '0};
    push_en             = 1'b0;
    push_val            = b;

    case (phase)
      swfr_pkg::PH_HUNT: begin
        if (b == swfr_pkg::FLAG_BYTE) phase_next = swfr_pkg::PH_FLAG;
      end
      swfr_pkg::PH_FLAG: begin
        if (b == swfr_pkg::FLAG_BYTE) phase_next = swfr_pkg::PH_FLAG;
        else if (b == address_byte)   phase_next = swfr_pkg::PH_ADDR;
        else                          phase_next = swfr_pkg::PH_HUNT;
      end
      swfr_pkg::PH_ADDR: begin
        if (b == swfr_pkg::FLAG_BYTE) begin
          phase_next = swfr_pkg::PH_FLAG;
        end else if (b == control_seq0 || b == control_seq1) begin
          seen_control_next = b;
          phase_next        = swfr_pkg::PH_CTRL;
        end else begin
          phase_next = swfr_pkg::PH_HUNT;
        end
      end
      swfr_pkg::PH_CTRL: begin
        if (b == swfr_pkg::FLAG_BYTE) begin
          phase_next = swfr_pkg::PH_FLAG;
        end else if (b != (address_byte ^ seen_control)) begin
          // BCC1 mismatch: back to the hunt
          phase_next = swfr_pkg::PH_HUNT;
        end else if (seen_control == want) begin
          phase_next          = swfr_pkg::PH_DATA;
          escape_pending_next = 1'b0;
          parity_acc_next     = '0;
          held_byte_next      = '0;
          held_valid_next     = 1'b0;
          byte_count_next     = '0;
        end else begin
          // duplicate frame: drop it up to its closing flag
          phase_next = swfr_pkg::PH_DROP;
        end
      end
      swfr_pkg::PH_DROP: begin
        if (b == swfr_pkg::FLAG_BYTE) begin
          phase_next = swfr_pkg::PH_HUNT;
          have_res   = 1'b1;
          res_new    = '{kind: swfr_pkg::RES_SEQ,
                         data: swfr_pkg::rr_code(expected_seq), len: '0};
        end
      end
      swfr_pkg::PH_DATA: begin
        if (b == swfr_pkg::FLAG_BYTE) begin
          // closing flag: the held byte is BCC2
          phase_next          = swfr_pkg::PH_HUNT;
          escape_pending_next = 1'b0;
          held_valid_next     = 1'b0;
          have_res            = 1'b1;
          if (!held_valid) begin
            res_new = '{kind: swfr_pkg::RES_REJECT,
                        data: swfr_pkg::rej_code(expected_seq), len: '0};
          end else if (held_byte == parity_acc) begin
            expected_seq_next = !expected_seq;
            res_new = '{kind: swfr_pkg::RES_ACCEPT,
                        data: swfr_pkg::rr_code(!expected_seq), len: byte_count};
          end else begin
            res_new = '{kind: swfr_pkg::RES_REJECT,
                        data: swfr_pkg::rej_code(expected_seq), len: byte_count};
          end
        end else if (escape_pending) begin
          // second byte of an escape; anything but 5E/5D is dropped
          escape_pending_next = 1'b0;
          if (b == swfr_pkg::ESC_FLAG) begin
            push_en  = 1'b1;
            push_val = swfr_pkg::FLAG_BYTE;
          end else if (b == swfr_pkg::ESC_ESC) begin
            push_en  = 1'b1;
            push_val = swfr_pkg::ESC_BYTE;
          end
        end else if (b == swfr_pkg::ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else begin
          push_en = 1'b1;
        end
      end
      default: begin
        phase_next = swfr_pkg::PH_HUNT;
      end
    endcase

    // one-byte delay line: release the previous byte as payload
    if (push_en) begin
      if (held_valid) begin
        have_res        = 1'b1;
        res_new         = '{kind: swfr_pkg::RES_PAYLOAD, data: held_byte, len: '0};
        parity_acc_next = parity_acc ^ held_byte;
        if (byte_count != swfr_pkg::LEN_MAX) byte_count_next = byte_count + 1'b1;
      end
      held_byte_next  = push_val;
      held_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= swfr_pkg::PH_HUNT;
      seen_control   <= '0;
      expected_seq   <= 1'b0;
      escape_pending <= 1'b0;
      parity_acc     <= '0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      byte_count     <= '0;
    end else if (rx_acc) begin
      phase          <= phase_next;
      seen_control   <= seen_control_next;
      expected_seq   <= expected_seq_next;
      escape_pending <= escape_pending_next;
      parity_acc     <= parity_acc_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      byte_count     <= byte_count_next;
    end
  end

  // ---- output register and skid ------------------------------------------
  assign pop  = out_valid && result.ready;
  assign push = rx_acc && have_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      // advance: skid moves up, or a fresh word refills the output
      if (skid_valid) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) out_word <= res_new;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_word  <= res_new;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.result_type    = out_word.kind;
  assign result.data_byte      = out_word.data;
  assign result.payload_length = out_word.len;

  // ---- assertions -------------------------------------------------------
  `SWFR_ASSERT_IMPLIES(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `SWFR_ASSERT_IMPLIES(a_held_in_data, held_valid, phase == swfr_pkg::PH_DATA, "held byte outside payload")
  `SWFR_ASSERT_IMPLIES(a_len_on_status, result.valid && (out_word.kind == swfr_pkg::RES_PAYLOAD || out_word.kind == swfr_pkg::RES_SEQ), out_word.len == '0, "length on non-status word")
  `SWFR_ASSERT_IMPLIES(a_seq_flip, expected_seq != $past(expected_seq), $past(push && res_new.kind == swfr_pkg::RES_ACCEPT), "sequence flipped without accept")

endmodule

>>> tb/tb_stop_wait_frame_receiver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stop_wait_frame_receiver
// Self-checking bench for the stop-and-wait frame receiver. Line bytes go in
// on the rx channel with random gaps, and results are drained with random
// back-pressure. A scoreboard tracks the header hunt, destuffing, the BCC2
// check and the sequence bit, and compares every result word in order.
// The register set is reprogrammed over APB between traffic blocks.
// ---------------------------------------------------------------------------
module tb_stop_wait_frame_receiver;

  localparam int STALL_LIMIT = 1000;  // cycles with no handshake on any port
  localparam int BLOCK_BYTES = 220;   // line bytes per register setting
  localparam int NUM_BLOCKS  = 9;

  // Short directed line at reset register values (address 03, seq0 00,
  // seq1 40). Frames in order: a good frame carrying a stuffed flag, a
  // stuffed escape, 00 and FF; an empty frame; a frame with the wrong
  // sequence; an invalid escape followed by a flag right after an escape;
  // a frame holding nothing but BCC2.
  localparam logic [7:0] DIRECTED [37] = '{
    swfr_pkg::FLAG_BYTE, swfr_pkg::ADDR_RESET, swfr_pkg::SEQ0_RESET,
    swfr_pkg::ADDR_RESET ^ swfr_pkg::SEQ0_RESET,
    swfr_pkg::ESC_BYTE, swfr_pkg::ESC_FLAG, swfr_pkg::ESC_BYTE, swfr_pkg::ESC_ESC,
    8'h00, 8'hFF,
    swfr_pkg::FLAG_BYTE ^ swfr_pkg::ESC_BYTE ^ 8'hFF, swfr_pkg::FLAG_BYTE,
    swfr_pkg::FLAG_BYTE, swfr_pkg::ADDR_RESET, swfr_pkg::SEQ1_RESET,
    swfr_pkg::ADDR_RESET ^ swfr_pkg::SEQ1_RESET, swfr_pkg::FLAG_BYTE,
    swfr_pkg::FLAG_BYTE, swfr_pkg::ADDR_RESET, swfr_pkg::SEQ0_RESET,
    swfr_pkg::ADDR_RESET ^ swfr_pkg::SEQ0_RESET, 8'h11, swfr_pkg::FLAG_BYTE,
    swfr_pkg::FLAG_BYTE, swfr_pkg::ADDR_RESET, swfr_pkg::SEQ1_RESET,
    swfr_pkg::ADDR_RESET ^ swfr_pkg::SEQ1_RESET,
    swfr_pkg::ESC_BYTE, 8'h22, swfr_pkg::ESC_BYTE, swfr_pkg::FLAG_BYTE,
    swfr_pkg::FLAG_BYTE, swfr_pkg::ADDR_RESET, swfr_pkg::SEQ1_RESET,
    swfr_pkg::ADDR_RESET ^ swfr_pkg::SEQ1_RESET, 8'h00, swfr_pkg::FLAG_BYTE
  };

  // -------------------------------------------------------------------------
  // Scoreboard: a bit-exact copy of the receiver state, fed with every
  // accepted line byte, holding the result words still owed by the block.
  // -------------------------------------------------------------------------
  class frame_scoreboard;
    logic [7:0]          addr_cfg;
    logic [7:0]          seq0_cfg;
    logic [7:0]          seq1_cfg;
    swfr_pkg::phase_t    phase;
    logic [7:0]          ctrl_seen;
    logic                exp_seq;
    logic                esc_pend;
    logic [7:0]          xor_acc;
    logic [7:0]          hold_byte;
    logic                hold_valid;
    logic [15:0]         count;
    swfr_pkg::res_word_t owed[$];
    int                  errors;

    function new();
      addr_cfg   = swfr_pkg::ADDR_RESET;
      seq0_cfg   = swfr_pkg::SEQ0_RESET;
      seq1_cfg   = swfr_pkg::SEQ1_RESET;
      phase      = swfr_pkg::PH_HUNT;
      ctrl_seen  = '0;
      exp_seq    = 1'b0;
      esc_pend   = 1'b0;
      xor_acc    = '0;
      hold_byte  = '0;
      hold_valid = 1'b0;
      count      = '0;
      errors     = 0;
    endfunction

    function void set_reg(swfr_pkg::reg_idx_t idx, logic [7:0] v);
      case (idx)
        swfr_pkg::REG_ADDRESS: addr_cfg = v;
        swfr_pkg::REG_SEQ0:    seq0_cfg = v;
        swfr_pkg::REG_SEQ1:    seq1_cfg = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] ack_code(logic s);
      return swfr_pkg::RR_BASE | {s, 7'd0};
    endfunction

    function logic [7:0] nak_code(logic s);
      return swfr_pkg::REJ_BASE | {s, 7'd0};
    endfunction

    function void owe(swfr_pkg::res_kind_t k, logic [7:0] d, logic [15:0] l);
      owed.push_back('{kind: k, data: d, len: l});
    endfunction

    // One-byte delay line: the newest destuffed byte may turn out to be BCC2.
    function void shift_in(logic [7:0] d);
      if (hold_valid) begin
        owe(swfr_pkg::RES_PAYLOAD, hold_byte, '0);
        xor_acc = xor_acc ^ hold_byte;
        if (count != swfr_pkg::LEN_MAX) count = count + 1'b1;
      end
      hold_byte  = d;
      hold_valid = 1'b1;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] want;
      case (phase)
        swfr_pkg::PH_HUNT: begin
          if (b == swfr_pkg::FLAG_BYTE) phase = swfr_pkg::PH_FLAG;
        end
        swfr_pkg::PH_FLAG: begin
          if (b == swfr_pkg::FLAG_BYTE) phase = swfr_pkg::PH_FLAG;
          else if (b == addr_cfg) phase = swfr_pkg::PH_ADDR;
          else phase = swfr_pkg::PH_HUNT;
        end
        swfr_pkg::PH_ADDR: begin
          if (b == swfr_pkg::FLAG_BYTE) begin
            phase = swfr_pkg::PH_FLAG;
          end else if (b == seq0_cfg || b == seq1_cfg) begin
            ctrl_seen = b;
            phase     = swfr_pkg::PH_CTRL;
          end else begin
            phase = swfr_pkg::PH_HUNT;
          end
        end
        swfr_pkg::PH_CTRL: begin
          want = exp_seq ? seq1_cfg : seq0_cfg;
          if (b == swfr_pkg::FLAG_BYTE) begin
            phase = swfr_pkg::PH_FLAG;
          end else if (b != (addr_cfg ^ ctrl_seen)) begin
            phase = swfr_pkg::PH_HUNT;
          end else if (ctrl_seen == want) begin
            phase      = swfr_pkg::PH_DATA;
            esc_pend   = 1'b0;
            xor_acc    = '0;
            hold_byte  = '0;
            hold_valid = 1'b0;
            count      = '0;
          end else begin
            phase = swfr_pkg::PH_DROP;
          end
        end
        swfr_pkg::PH_DROP: begin
          if (b == swfr_pkg::FLAG_BYTE) begin
            phase = swfr_pkg::PH_HUNT;
            owe(swfr_pkg::RES_SEQ, ack_code(exp_seq), '0);
          end
        end
        swfr_pkg::PH_DATA: begin
          if (b == swfr_pkg::FLAG_BYTE) begin
            phase    = swfr_pkg::PH_HUNT;
            esc_pend = 1'b0;
            if (!hold_valid) begin
              owe(swfr_pkg::RES_REJECT, nak_code(exp_seq), '0);
            end else begin
              hold_valid = 1'b0;
              if (hold_byte == xor_acc) begin
                exp_seq = ~exp_seq;
                owe(swfr_pkg::RES_ACCEPT, ack_code(exp_seq), count);
              end else begin
                owe(swfr_pkg::RES_REJECT, nak_code(exp_seq), count);
              end
            end
          end else if (esc_pend) begin
            esc_pend = 1'b0;
            if (b == swfr_pkg::ESC_FLAG) shift_in(swfr_pkg::FLAG_BYTE);
            else if (b == swfr_pkg::ESC_ESC) shift_in(swfr_pkg::ESC_BYTE);
          end else if (b == swfr_pkg::ESC_BYTE) begin
            esc_pend = 1'b1;
          end else begin
            shift_in(b);
          end
        end
        default: phase = swfr_pkg::PH_HUNT;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(swfr_pkg::res_kind_t k, logic [7:0] d, logic [15:0] l);
      swfr_pkg::res_word_t w;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result type %0d data %02h length %0d",
                         k, d, l));
        return;
      end
      w = owed.pop_front();
      if (k != w.kind)
        report($sformatf("result_type got %0d want %0d", k, w.kind));
      if (d != w.data)
        report($sformatf("data_byte got %02h want %02h (type %0d)", d, w.data, w.kind));
      if (l != w.len)
        report($sformatf("payload_length got %0d want %0d (type %0d)", l, w.len, w.kind));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Clock, channels and the block
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [swfr_pkg::CFG_AW-1:0] paddr;
  logic [swfr_pkg::CFG_DW-1:0] pwdata;
  logic [swfr_pkg::CFG_DW-1:0] prdata;
  logic pready;

  swfr_rx_if  rx_ch ();
  swfr_res_if res_ch ();

  always #1 clk = ~clk;

  stop_wait_frame_receiver i_dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_scoreboard sb = new();

  int         src_idle  = 25;  // percent of cycles the sender holds back
  int         sink_idle = 73;  // percent of cycles the receiver stalls
  int         bytes_sent = 0;
  int         idle_cycles = 0;
  logic [7:0] line_q[$];       // line bytes waiting to be sent

  // -------------------------------------------------------------------------
  // Result side: stall at random, check every word taken.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_word(swfr_pkg::res_kind_t'(res_ch.result_type), res_ch.data_byte,
                    res_ch.payload_length);
  end

  // Watchdog: drop the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // Offer one line byte, with random gaps ahead of it, and hold it until the
  // block takes the word. The scoreboard sees it in this same process, so the
  // frame builder always works from an up-to-date sequence bit.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_byte(line_q.pop_front());
  endtask

  // Stop the line and wait until every owed word has come out, then let the
  // block settle whatever produced no result.
  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup then access; psel is left high for back-to-back writes.
  task automatic write_reg(input swfr_pkg::reg_idx_t idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= swfr_pkg::CFG_AW'({idx, 2'b00});
    pwdata  <= swfr_pkg::CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config(input logic [7:0] a, input logic [7:0] s0,
                              input logic [7:0] s1);
    drain();
    write_reg(swfr_pkg::REG_ADDRESS, a);
    write_reg(swfr_pkg::REG_SEQ0, s0);
    write_reg(swfr_pkg::REG_SEQ1, s1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Line content
  // -------------------------------------------------------------------------

  // Random byte leaning toward flag, escape and the all-zero/all-one values.
  function automatic logic [7:0] rand_line_byte();
    case ($urandom_range(19))
      0: return swfr_pkg::FLAG_BYTE;
      1: return swfr_pkg::ESC_BYTE;
      2: return swfr_pkg::ESC_FLAG;
      3: return swfr_pkg::ESC_ESC;
      4: return 8'h00;
      5: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_stuffed(input logic [7:0] d);
    if (d == swfr_pkg::FLAG_BYTE || d == swfr_pkg::ESC_BYTE) begin
      line_q.push_back(swfr_pkg::ESC_BYTE);
      line_q.push_back((d == swfr_pkg::FLAG_BYTE) ? swfr_pkg::ESC_FLAG : swfr_pkg::ESC_ESC);
    end else begin
      line_q.push_back(d);
    end
  endfunction

  // Queue one information frame of n payload bytes. With faults set, drop the
  // opening flag now and then, slip in invalid escapes, flip BCC2 bits or
  // abort with an escape right before the closing flag.
  function automatic void add_frame(input bit right_seq, input int n, input bit faults);
    logic [7:0] ctrl;
    logic [7:0] bcc;
    logic [7:0] d;
    ctrl = (sb.exp_seq ^ !right_seq) ? sb.seq1_cfg : sb.seq0_cfg;
    bcc  = '0;
    if (!faults || $urandom_range(9) != 0) line_q.push_back(swfr_pkg::FLAG_BYTE);
    line_q.push_back(sb.addr_cfg);
    line_q.push_back(ctrl);
    line_q.push_back(sb.addr_cfg ^ ctrl);
    for (int i = 0; i < n; i++) begin
      d   = rand_line_byte();
      bcc = bcc ^ d;
      add_stuffed(d);
      if (faults && $urandom_range(29) == 0) begin
        d = 8'($urandom);
        if (d == swfr_pkg::ESC_FLAG || d == swfr_pkg::ESC_ESC || d == swfr_pkg::FLAG_BYTE)
          d = d ^ 8'h01;
        line_q.push_back(swfr_pkg::ESC_BYTE);
        line_q.push_back(d);
      end
    end
    // A zero-length frame goes out either empty or carrying only BCC2.
    if (n > 0 || $urandom_range(1) == 1) begin
      if (faults && $urandom_range(6) == 0) bcc = bcc ^ 8'(1 << $urandom_range(7));
      add_stuffed(bcc);
    end
    if (faults && $urandom_range(19) == 0) line_q.push_back(swfr_pkg::ESC_BYTE);
    line_q.push_back(swfr_pkg::FLAG_BYTE);
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int          start;
    int          pick;
    int          len;
    logic [7:0]  ctl;

    // Drive every input to a known value before the first edge; the result
    // side ready comes from its own process.
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed line at the reset register values.
    foreach (DIRECTED[i]) line_q.push_back(DIRECTED[i]);
    send_line();

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      // Idling: sender light / receiver heavy, then swapped, then none.
      if (blk == 3) begin
        src_idle  = 73;
        sink_idle = 25;
      end else if (blk == 6) begin
        src_idle  = 0;
        sink_idle = 0;
      end

      case (blk)
        0, 6: apply_config(swfr_pkg::ADDR_RESET, swfr_pkg::SEQ0_RESET, swfr_pkg::SEQ1_RESET);
        1: apply_config(8'h00, 8'hFF, 8'h00);
        2: apply_config(8'hFF, 8'h00, 8'hFF);
        3: begin
          // Both sequences share one control value.
          ctl = 8'($urandom);
          apply_config(8'($urandom), ctl, ctl);
        end
        default: apply_config(8'($urandom), 8'($urandom), 8'($urandom));
      endcase

      start = bytes_sent;
      while (bytes_sent - start < BLOCK_BYTES) begin
        pick = $urandom_range(99);
        len  = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
        if (pick < 70) begin
          add_frame(1'b1, len, 1'b1);
        end else if (pick < 82) begin
          add_frame(1'b0, len, 1'b1);
        end else if (pick < 90) begin
          // Header that may break at the address, the control or BCC1.
          line_q.push_back(swfr_pkg::FLAG_BYTE);
          line_q.push_back($urandom_range(1) ? sb.addr_cfg : rand_line_byte());
          line_q.push_back($urandom_range(1) ? sb.seq0_cfg : rand_line_byte());
          line_q.push_back(rand_line_byte());
          line_q.push_back(rand_line_byte());
          line_q.push_back(swfr_pkg::FLAG_BYTE);
        end else begin
          repeat ($urandom_range(1, 6)) line_q.push_back(rand_line_byte());
        end
        send_line();
      end
    end

    // Flush everything owed, then settle before the verdict.
    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/swfr_pkg.sv
rtl/swfr_rx_if.sv
rtl/swfr_res_if.sv
rtl/stop_wait_frame_receiver.sv
tb/tb_stop_wait_frame_receiver.sv
